// ----- design/dqqp_pkg.sv -----
// ----------------------------------------------------------------------------
// dqqp_pkg
// Shared types and constants of the DNS question parser: request and result
// payload structs, record kind codes and parser phase encoding.
// ----------------------------------------------------------------------------
package dqqp_pkg;

  // Number of bytes in the fixed DNS message header.
  localparam int unsigned HEADER_BYTES = 12;
  // Number of 16-bit words in the header.
  localparam int unsigned HEADER_WORDS = HEADER_BYTES / 2;
  // Depth of the result queue; must hold at least two records.
  localparam int unsigned RESULT_DEPTH = 4;

  typedef enum logic [1:0] {
    KIND_QUESTION = 2'd0,
    KIND_ACCEPT   = 2'd1,
    KIND_ERROR    = 2'd2
  } record_kind_t;

  typedef enum logic [4:0] {
    PH_HEADER     = 5'b00001,
    PH_LABEL_LEN  = 5'b00010,
    PH_LABEL_BODY = 5'b00100,
    PH_TYPECLASS  = 5'b01000,
    PH_DONE       = 5'b10000
  } phase_t;

  typedef struct packed {
    logic [7:0] byte_value;
    logic       last_byte;
  } request_t;

  typedef struct packed {
    logic [1:0]  record_kind;
    logic [15:0] question_index;
    logic [15:0] query_type;
    logic [15:0] query_class;
    logic [15:0] message_id;
    logic [15:0] flag_word;
    logic [15:0] question_count;
    logic [15:0] answer_count;
    logic [15:0] authority_count;
    logic [15:0] additional_count;
    logic        run_end;
  } result_t;

endpackage

// ----- design/dns_query_question_parser_core.sv -----
// ----------------------------------------------------------------------------
// dns_query_question_parser_core
// Parses the header and question section of a DNS message delivered one
// byte per request, emitting one record per question and an end record.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake                    Payload     Content
//  -------   --------------------------   ---------   ---------------------------
//  request   byte_valid / byte_ready      byte_item   one message byte, last flag
//  result    result_valid / result_ready  result      question or end record
//
// One request is taken per cycle while byte_ready is high. Each request
// updates the parser state in a single registered step, and the records it
// causes are written together into a small result queue; with the queue empty
// the first is visible the cycle after the request is taken. A second record
// comes only on the final byte. byte_ready stays high while the queue has room
// for two records, so a result-side stall holds off requests only when it lacks that room.
// Reset (rst, synchronous) returns the parser to the header phase and
// empties the queue.
//
module dns_query_question_parser_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               byte_valid,
  output logic               byte_ready,
  input  dqqp_pkg::request_t byte_item,
  output logic               result_valid,
  input  logic               result_ready,
  output dqqp_pkg::result_t  result
);
  import dqqp_pkg::*;

  localparam int unsigned PTR_W = $clog2(RESULT_DEPTH);
  localparam int unsigned CNT_W = $clog2(RESULT_DEPTH + 1);

  // Parser state.
  phase_t      phase, phase_next;
  logic [3:0]  header_byte_count, header_byte_count_next;
  logic [15:0] header_words [HEADER_WORDS];
  logic [15:0] header_words_next [HEADER_WORDS];
  logic [15:0] questions_done, questions_done_next;
  logic [7:0]  label_bytes_left, label_bytes_left_next;
  logic [1:0]  tail_byte_count, tail_byte_count_next;
  logic [23:0] type_class_latch, type_class_latch_next;

  // Records produced by the current request.
  result_t     question_rec, end_rec;
  logic        question_fire;
  logic        end_fire;

  // Result queue.
  result_t          queue [RESULT_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  logic             take;
  logic             pop;
  logic [1:0]       push_n;
  logic [2:0]       hw_idx;

  // Room for the worst case of two records from one request.
  assign byte_ready   = (count <= CNT_W'(RESULT_DEPTH - 2));
  assign take         = byte_valid && byte_ready;
  assign result_valid = (count != '0);
  assign pop          = result_valid && result_ready;
  assign result       = queue[rd_ptr];
  assign hw_idx       = header_byte_count[3:1];

  // Next-state logic for one byte.
  always_comb begin
    phase_next             = phase;
    header_byte_count_next = header_byte_count;
    header_words_next      = header_words;
    questions_done_next    = questions_done;
    label_bytes_left_next  = label_bytes_left;
    tail_byte_count_next   = tail_byte_count;
    type_class_latch_next  = type_class_latch;
    question_fire          = 1'b0;
    end_fire               = 1'b0;
    question_rec           = '0;
    end_rec                = '0;

    question_rec.record_kind    = KIND_QUESTION;
    question_rec.question_index = questions_done;
    question_rec.query_type     = type_class_latch[23:8];
    question_rec.query_class    = {type_class_latch[7:0], byte_item.byte_value};
    question_rec.run_end        = !byte_item.last_byte;

    case (phase)
      PH_HEADER: begin
        header_words_next[hw_idx] = {header_words[hw_idx][7:0], byte_item.byte_value};
        header_byte_count_next    = header_byte_count + 4'd1;
        if (header_byte_count_next >= 4'(HEADER_BYTES)) begin
          phase_next = (header_words_next[2] == 16'd0) ? PH_DONE : PH_LABEL_LEN;
        end
      end
      PH_LABEL_LEN: begin
        if (byte_item.byte_value == 8'd0) begin
          phase_next            = PH_TYPECLASS;
          tail_byte_count_next  = 2'd0;
          type_class_latch_next = '0;
        end else begin
          label_bytes_left_next = byte_item.byte_value;
          phase_next            = PH_LABEL_BODY;
        end
      end
      PH_LABEL_BODY: begin
        label_bytes_left_next = label_bytes_left - 8'd1;
        if (label_bytes_left_next == 8'd0) begin
          phase_next = PH_LABEL_LEN;
        end
      end
      PH_TYPECLASS: begin
        if (tail_byte_count != 2'd3) begin
          type_class_latch_next = {type_class_latch[15:0], byte_item.byte_value};
          tail_byte_count_next  = tail_byte_count + 2'd1;
        end else begin
          question_fire         = 1'b1;
          questions_done_next   = questions_done + 16'd1;
          tail_byte_count_next  = 2'd0;
          type_class_latch_next = '0;
          phase_next = (questions_done_next == header_words[2]) ? PH_DONE : PH_LABEL_LEN;
        end
      end
      default: begin
      end
    endcase

    // The end record judges the phase reached after this byte, but a message
    // still in its header when the final byte arrives is always malformed.
    if (byte_item.last_byte) begin
      end_fire        = 1'b1;
      end_rec.run_end = 1'b1;
      if (phase != PH_HEADER && phase_next == PH_DONE) begin
        end_rec.record_kind      = KIND_ACCEPT;
        end_rec.message_id       = header_words[0];
        end_rec.flag_word        = header_words[1];
        end_rec.question_count   = header_words[2];
        end_rec.answer_count     = header_words[3];
        end_rec.authority_count  = header_words[4];
        end_rec.additional_count = header_words[5];
      end else begin
        end_rec.record_kind = KIND_ERROR;
      end
      // Start the next message from a clean state.
      phase_next             = PH_HEADER;
      header_byte_count_next = '0;
      for (int i = 0; i < HEADER_WORDS; i++) begin
        header_words_next[i] = '0;
      end
      questions_done_next    = '0;
      label_bytes_left_next  = '0;
      tail_byte_count_next   = '0;
      type_class_latch_next  = '0;
    end
  end

  assign push_n = take ? ({1'b0, question_fire} + {1'b0, end_fire}) : 2'd0;

  // Parser state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= PH_HEADER;
      header_byte_count <= '0;
      for (int i = 0; i < HEADER_WORDS; i++) begin
        header_words[i] <= '0;
      end
      questions_done    <= '0;
      label_bytes_left  <= '0;
      tail_byte_count   <= '0;
      type_class_latch  <= '0;
    end else if (take) begin
      phase             <= phase_next;
      header_byte_count <= header_byte_count_next;
      header_words      <= header_words_next;
      questions_done    <= questions_done_next;
      label_bytes_left  <= label_bytes_left_next;
      tail_byte_count   <= tail_byte_count_next;
      type_class_latch  <= type_class_latch_next;
    end
  end

  // Result queue control.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + PTR_W'(push_n);
      if (pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      count <= count + CNT_W'(push_n) - CNT_W'(pop);
    end
  end

  // Result queue storage.
  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      queue[wr_ptr] <= question_fire ? question_rec : end_rec;
    end
    if (push_n == 2'd2) begin
      queue[wr_ptr + PTR_W'(1)] <= end_rec;
    end
  end

endmodule

// ----- tb/dqqp_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// dqqp_checker
// Watches both channels of the DNS question parser, keeps its own copy of
// the parser state to predict the records of every accepted request, and
// compares each delivered record with the oldest prediction.
// ----------------------------------------------------------------------------
module dqqp_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               byte_valid,
  input  logic               byte_ready,
  input  dqqp_pkg::request_t byte_item,
  input  logic               result_valid,
  input  logic               result_ready,
  input  dqqp_pkg::result_t  result,
  output int                 mismatches,
  output int                 outstanding
);
  import dqqp_pkg::*;

  // Header word positions in arrival order.
  localparam int unsigned ID_WORD    = 0;
  localparam int unsigned FLAGS_WORD = 1;
  localparam int unsigned QD_WORD    = 2;
  localparam int unsigned AN_WORD    = 3;
  localparam int unsigned NS_WORD    = 4;
  localparam int unsigned AR_WORD    = 5;

  phase_t      parse_phase;
  logic [3:0]  hdr_count;
  logic [15:0] hdr_words [HEADER_WORDS];
  logic [15:0] questions_seen;
  logic [7:0]  label_left;
  logic [1:0]  tail_count;
  logic [23:0] tail_latch;

  result_t     predicted_records [$];
  result_t     oldest;
  int          err_total = 0;

  task automatic clear_parser();
    int unsigned i;
    parse_phase    = PH_HEADER;
    hdr_count      = '0;
    for (i = 0; i < HEADER_WORDS; i++) hdr_words[i] = '0;
    questions_seen = '0;
    label_left     = '0;
    tail_count     = '0;
    tail_latch     = '0;
  endtask

  // Advances the parser copy by one byte and queues the records it causes.
  task automatic predict_records(input request_t req);
    result_t     q_rec;
    result_t     e_rec;
    bit          have_q;
    bit          was_header;
    int unsigned w;
    have_q     = 1'b0;
    q_rec      = '0;
    e_rec      = '0;
    was_header = (parse_phase == PH_HEADER);
    case (parse_phase)
      PH_HEADER: begin
        w = hdr_count >> 1;
        hdr_words[w] = {hdr_words[w][7:0], req.byte_value};
        hdr_count = hdr_count + 4'd1;
        if (hdr_count >= HEADER_BYTES)
          parse_phase = (hdr_words[QD_WORD] == 16'd0) ? PH_DONE : PH_LABEL_LEN;
      end
      PH_LABEL_LEN: begin
        if (req.byte_value == 8'd0) begin
          parse_phase = PH_TYPECLASS;
          tail_count  = '0;
          tail_latch  = '0;
        end else begin
          label_left  = req.byte_value;
          parse_phase = PH_LABEL_BODY;
        end
      end
      PH_LABEL_BODY: begin
        label_left = label_left - 8'd1;
        if (label_left == 8'd0) parse_phase = PH_LABEL_LEN;
      end
      PH_TYPECLASS: begin
        if (tail_count < 2'd3) begin
          tail_latch = {tail_latch[15:0], req.byte_value};
          tail_count = tail_count + 2'd1;
        end else begin
          have_q               = 1'b1;
          q_rec.record_kind    = KIND_QUESTION;
          q_rec.question_index = questions_seen;
          q_rec.query_type     = tail_latch[23:8];
          q_rec.query_class    = {tail_latch[7:0], req.byte_value};
          questions_seen       = questions_seen + 16'd1;
          tail_count           = '0;
          tail_latch           = '0;
          parse_phase = (questions_seen == hdr_words[QD_WORD]) ? PH_DONE : PH_LABEL_LEN;
        end
      end
      default: ;
    endcase

    if (req.last_byte) begin
      if (!was_header && parse_phase == PH_DONE) begin
        e_rec.record_kind      = KIND_ACCEPT;
        e_rec.message_id       = hdr_words[ID_WORD];
        e_rec.flag_word        = hdr_words[FLAGS_WORD];
        e_rec.question_count   = hdr_words[QD_WORD];
        e_rec.answer_count     = hdr_words[AN_WORD];
        e_rec.authority_count  = hdr_words[NS_WORD];
        e_rec.additional_count = hdr_words[AR_WORD];
      end else begin
        e_rec.record_kind = KIND_ERROR;
      end
      e_rec.run_end = 1'b1;
      if (have_q) predicted_records.push_back(q_rec);
      predicted_records.push_back(e_rec);
      clear_parser();
    end else if (have_q) begin
      q_rec.run_end = 1'b1;
      predicted_records.push_back(q_rec);
    end
  endtask

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      err_total++;
    end
  endtask

  initial clear_parser();

  always @(posedge clk) begin
    if (rst) begin
      clear_parser();
      predicted_records.delete();
    end else begin
      if (byte_valid && byte_ready) predict_records(byte_item);
      if (result_valid && result_ready) begin
        if (predicted_records.size() == 0) begin
          $error("record kind %0d delivered with nothing predicted", result.record_kind);
          err_total++;
        end else begin
          oldest = predicted_records.pop_front();
          check_field("record_kind", 16'(oldest.record_kind), 16'(result.record_kind));
          check_field("question_index", oldest.question_index, result.question_index);
          check_field("query_type", oldest.query_type, result.query_type);
          check_field("query_class", oldest.query_class, result.query_class);
          check_field("message_id", oldest.message_id, result.message_id);
          check_field("flag_word", oldest.flag_word, result.flag_word);
          check_field("question_count", oldest.question_count, result.question_count);
          check_field("answer_count", oldest.answer_count, result.answer_count);
          check_field("authority_count", oldest.authority_count, result.authority_count);
          check_field("additional_count", oldest.additional_count,
                      result.additional_count);
          check_field("run_end", 16'(oldest.run_end), 16'(result.run_end));
        end
      end
    end
    mismatches  <= err_total;
    outstanding <= predicted_records.size();
  end

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the DNS question parser core. Feeds directed
// messages and then a long stream of random well-formed, truncated, short
// and noise messages with random gaps and result-side stalls, and relies on
// the checker beside the block for prediction and comparison.
// ----------------------------------------------------------------------------
module tb;
  import dqqp_pkg::*;

  // Stimulus stops once about this many random request bytes have gone in.
  localparam int unsigned RANDOM_BYTES    = 1900;
  localparam int unsigned RESET_CYCLES    = 4;
  // Long result-side hold-off so the result queue fills and byte_ready drops.
  localparam int unsigned HOLD_OFF_CYCLES = 400;
  // Cycles without any accepted request or record before the run is abandoned.
  // The longest legal quiet stretch is the hold-off plus one long stall.
  localparam int unsigned WATCHDOG_LIMIT  = 5000;
  // Extra wait after the checker has no outstanding predictions left.
  localparam int unsigned DRAIN_CYCLES    = 16;

  typedef enum {
    SHAPE_WELL_FORMED,
    SHAPE_TRUNCATED,
    SHAPE_SHORT,
    SHAPE_NOISE
  } msg_shape_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        byte_valid;
  logic        byte_ready;
  request_t    byte_item;
  logic        result_valid;
  logic        result_ready;
  result_t     result;

  int          mismatches;
  int          outstanding;
  int unsigned idle_cycles = 0;
  int unsigned bytes_sent;
  bit          steady_sender = 1'b0;
  bit          hold_off_req = 1'b0;
  logic [7:0]  msg_bytes [$];

  always #4 clk = ~clk;

  dns_query_question_parser_core dut (
    .clk          (clk),
    .rst          (rst),
    .byte_valid   (byte_valid),
    .byte_ready   (byte_ready),
    .byte_item    (byte_item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  dqqp_checker scoreboard (
    .clk          (clk),
    .rst          (rst),
    .byte_valid   (byte_valid),
    .byte_ready   (byte_ready),
    .byte_item    (byte_item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .mismatches   (mismatches),
    .outstanding  (outstanding)
  );

  // Sender gap before each request. Most are zero or short, a few are long,
  // and whole messages go out back to back while steady_sender is set.
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (steady_sender) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(30, 80);
  endfunction

  function automatic logic [15:0] rand_word();
    return 16'($urandom_range(0, 65535));
  endfunction

  // Offers one request and returns at the edge where it is accepted. Valid
  // stays high across back-to-back requests; it only drops for a real gap.
  task automatic send_byte(input logic [7:0] value, input logic last);
    request_t    req;
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      byte_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req.byte_value = value;
    req.last_byte  = last;
    byte_valid <= 1'b1;
    byte_item  <= req;
    do @(posedge clk); while (!byte_ready);
    bytes_sent++;
  endtask

  task automatic send_message();
    int i;
    for (i = 0; i < msg_bytes.size(); i++)
      send_byte(msg_bytes[i], i == msg_bytes.size() - 1);
  endtask

  task automatic add_word(input logic [15:0] w);
    msg_bytes.push_back(w[15:8]);
    msg_bytes.push_back(w[7:0]);
  endtask

  task automatic add_header(input logic [15:0] id, input logic [15:0] flags,
                            input logic [15:0] qd, input logic [15:0] an,
                            input logic [15:0] ns, input logic [15:0] ar);
    add_word(id);
    add_word(flags);
    add_word(qd);
    add_word(an);
    add_word(ns);
    add_word(ar);
  endtask

  // One question: up to three labels, then the zero terminator, QTYPE and
  // QCLASS. Label lengths are mostly short; rarely a length in the range of
  // a compression pointer shows up, which the parser must treat as a plain
  // length and skip that many bytes.
  task automatic add_question();
    int unsigned labels;
    int unsigned len;
    int unsigned r;
    labels = $urandom_range(0, 3);
    repeat (labels) begin
      r = $urandom_range(0, 299);
      if (r == 0) len = $urandom_range(192, 255);
      else if (r < 6) len = $urandom_range(9, 63);
      else len = $urandom_range(1, 8);
      msg_bytes.push_back(8'(len));
      repeat (len) msg_bytes.push_back(8'($urandom_range(0, 255)));
    end
    msg_bytes.push_back(8'h00);
    add_word(rand_word());
    add_word(rand_word());
  endtask

  function automatic msg_shape_t pick_shape();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return SHAPE_WELL_FORMED;
    if (r < 75) return SHAPE_TRUNCATED;
    if (r < 85) return SHAPE_SHORT;
    return SHAPE_NOISE;
  endfunction

  // Most messages are well formed with random content so the parser walks
  // through every phase; the rest are cut short, too short for a header, or
  // plain noise, where the header question count is random as well.
  task automatic build_random_message();
    msg_shape_t  shape;
    int unsigned n_q;
    int unsigned cut;
    msg_bytes.delete();
    shape = pick_shape();
    case (shape)
      SHAPE_WELL_FORMED: begin
        n_q = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 3);
        add_header(rand_word(), rand_word(), 16'(n_q), rand_word(), rand_word(),
                   rand_word());
        repeat (n_q) add_question();
        // Trailing bytes after the counted questions must be ignored.
        if ($urandom_range(0, 1) == 1)
          repeat ($urandom_range(1, 3)) msg_bytes.push_back(8'($urandom_range(0, 255)));
      end
      SHAPE_TRUNCATED: begin
        n_q = $urandom_range(1, 3);
        add_header(rand_word(), rand_word(), 16'(n_q), rand_word(), rand_word(),
                   rand_word());
        repeat (n_q) add_question();
        cut = $urandom_range(1, msg_bytes.size() - 1);
        while (msg_bytes.size() > cut) void'(msg_bytes.pop_back());
      end
      SHAPE_SHORT: begin
        repeat ($urandom_range(1, HEADER_BYTES))
          msg_bytes.push_back(8'($urandom_range(0, 255)));
      end
      default: begin
        repeat ($urandom_range(HEADER_BYTES + 1, 40))
          msg_bytes.push_back(8'($urandom_range(0, 255)));
      end
    endcase
  endtask

  // Result side. It mixes runs of steady acceptance with short and long
  // stalls, and once, on request from the stimulus, holds off for a long
  // stretch while requests keep coming so that the block backs up.
  initial begin
    int unsigned r;
    int unsigned run_len;
    result_ready <= 1'b0;
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        result_ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end else begin
        r = $urandom_range(0, 99);
        if (r < 50) begin
          result_ready <= 1'b1;
          run_len = (r < 5) ? $urandom_range(40, 80) : $urandom_range(1, 20);
        end else begin
          result_ready <= 1'b0;
          if (r < 90) run_len = $urandom_range(1, 3);
          else if (r < 97) run_len = $urandom_range(4, 12);
          else run_len = $urandom_range(30, 80);
        end
        repeat (run_len) @(posedge clk);
      end
    end
  end

  // Watchdog: any cycle with an accepted request or record restarts the count.
  always @(posedge clk) begin
    if (rst || (byte_valid && byte_ready) || (result_valid && result_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("dns_query_question_parser_core verification failed");
        $finish;
      end
    end
  end

  initial begin
    rst        <= 1'b1;
    byte_valid <= 1'b0;
    byte_item  <= '0;
    bytes_sent = 0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // Directed: a message that ends exactly on the twelfth header byte is
    // still a short message and must be rejected, even with a zero question
    // count that would otherwise finish the parse.
    msg_bytes.delete();
    add_header(16'h0000, 16'hFFFF, 16'h0000, 16'h0000, 16'hFFFF, 16'h0000);
    send_message();

    // Directed: one question with a root name and extreme QTYPE/QCLASS,
    // followed by a trailing byte that looks like a compression pointer and
    // must be ignored, so the message is accepted with its header words.
    msg_bytes.delete();
    add_header(16'hFFFF, 16'h0000, 16'h0001, 16'hFFFF, 16'h0000, 16'hFFFF);
    msg_bytes.push_back(8'h00);
    add_word(16'hFFFF);
    add_word(16'h0000);
    msg_bytes.push_back(8'hC0);
    send_message();

    // Random part; the long result-side hold-off starts near its beginning.
    hold_off_req = 1'b1;
    bytes_sent = 0;
    while (bytes_sent < RANDOM_BYTES) begin
      build_random_message();
      steady_sender = ($urandom_range(0, 3) == 0);
      send_message();
    end
    byte_valid <= 1'b0;

    // Wait for the checker to account for the last request before the
    // outstanding count is trusted.
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0 && outstanding == 0) begin
      $display("dns_query_question_parser_core verification clean");
    end else begin
      $display("dns_query_question_parser_core verification failed");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
design/dqqp_pkg.sv
design/dns_query_question_parser_core.sv
tb/dqqp_checker.sv
tb/tb.sv
